FILE: rtl/core/utc_to_local_hour_with_dst_core_macros.svh
// ----------------------------------------------------------------------------
// UTC to local hour core: assertion macros
// Shared concurrent assertion forms, clocked on clk and idle during reset.
// ----------------------------------------------------------------------------
`ifndef UTC_TO_LOCAL_HOUR_WITH_DST_CORE_MACROS_SVH
`define UTC_TO_LOCAL_HOUR_WITH_DST_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UTLD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define UTLD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/utld_pkg.sv
// ----------------------------------------------------------------------------
// UTC to local hour package
// Field widths, calendar constants and shared types of the conversion core.
// ----------------------------------------------------------------------------
`default_nettype none

package utld_pkg;

    // Field widths
    localparam int HOUR_W   = 5;
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 7;
    localparam int OFFSET_W = 5;

    // Stream payload widths, padded to whole bytes
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 8;

    // Configuration register indexes
    localparam logic REG_ZONE_OFFSET = 1'b0;
    localparam logic REG_DST_ENABLE  = 1'b1;

    // Calendar constants
    localparam logic signed [OFFSET_W-1:0] OFFSET_MIN = -5'sd12;
    localparam logic signed [OFFSET_W-1:0] OFFSET_MAX = 5'sd14;
    localparam logic [HOUR_W-1:0]  LAST_HOUR       = 5'd23;
    localparam logic [HOUR_W-1:0]  DST_SWITCH_HOUR = 5'd2;
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd10;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // One input item
    typedef struct packed {
        logic [YEAR_W-1:0]  year_low;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hour;
    } utld_item_t;

    // Conversion result
    typedef struct packed {
        logic [HOUR_W-1:0] local_hour;
        logic              dst_on;
    } utld_calc_t;

endpackage

`default_nettype wire

FILE: rtl/core/utc_to_local_hour_with_dst_core.sv
// ----------------------------------------------------------------------------
// UTC to local hour with US daylight saving
// Converts a UTC hour and date to the local hour for a whole-hour zone.
// ----------------------------------------------------------------------------
// Each request (UTC hour, day, month, year 2000 plus two digits) yields one local
// hour: it lands in an input register, passes one pass of calendar logic (offset,
// day carry, weekday, DST window) and is caught in the result register. One request
// is taken every cycle while the output is not stalled; the input register advances
// whenever the result register is empty or being read, so a stalled output holds up
// to two requests before tready drops. The user must write the zone offset and DST
// enable through the configuration port only while no request is in flight; the
// block does not enforce this.
`default_nettype none
`include "utc_to_local_hour_with_dst_core_macros.svh"

module utc_to_local_hour_with_dst_core
    import utld_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration write port
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [OFFSET_W-1:0]   cfg_wdata,
    // Request stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [4:0] utc_hour, [9:5] utc_day, [13:10] utc_month, [20:14] utc_year_low
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // Result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [4:0] local_hour
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic signed [OFFSET_W-1:0] zone_offset_reg;
    logic                       dst_enable_reg;
    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    utld_item_t                 s1_item_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [HOUR_W-1:0]          out_hour_reg;
    logic                       s1_move;
    logic                       in_take;
    utld_item_t                 in_item;
    utld_calc_t                 calc_res;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_offset_reg <= '0;
            dst_enable_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ZONE_OFFSET: zone_offset_reg <= $signed(cfg_wdata);
                REG_DST_ENABLE:  dst_enable_reg  <= cfg_wdata[0];
                default:         ;
            endcase
        end
    end

    // Pipeline flow control.
    assign s1_move       = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_move;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign s1_valid_next = in_take || (s1_valid_reg && !s1_move);
    assign out_valid_next = s1_move || (out_valid_reg && !m_axis_tready);

    // Unpack the request.
    assign in_item.hour     = s_axis_tdata[4:0];
    assign in_item.day      = s_axis_tdata[9:5];
    assign in_item.month    = s_axis_tdata[13:10];
    assign in_item.year_low = s_axis_tdata[20:14];

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input and result payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_item_reg <= in_item;
        end
        if (s1_move)
        begin
            out_hour_reg <= calc_res.local_hour;
        end
    end

    // Conversion logic between the two registers.
    utld_calc u_calc (
        .item        (s1_item_reg),
        .zone_offset (zone_offset_reg),
        .dst_enable  (dst_enable_reg),
        .res         (calc_res)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-HOUR_W){1'b0}}, out_hour_reg};

    // Checks on the pipeline and the conversion.
    `UTLD_ASSERT_SAME(a_hour_range, m_axis_tvalid, (out_hour_reg <= LAST_HOUR), "local hour above 23")
    `UTLD_ASSERT_SAME(a_dst_gated, s1_valid_reg && !dst_enable_reg, !calc_res.dst_on, "DST applied while disabled")
    `UTLD_ASSERT_NEXT(a_stage_move, s1_move, m_axis_tvalid, "moved request lost before output")
    `UTLD_ASSERT_SAME(a_no_overrun, in_take && s1_valid_reg, s1_move, "input register overwritten")

endmodule

`default_nettype wire

FILE: rtl/core/utld_calc.sv
// ----------------------------------------------------------------------------
// UTC to local hour calculation
// Single-pass logic: zone offset, one-day date carry, weekday and US DST rule.
// ----------------------------------------------------------------------------
`default_nettype none

module utld_calc
    import utld_pkg::*;
(
    input  utld_item_t                   item,
    input  logic signed [OFFSET_W-1:0]   zone_offset,
    input  logic                         dst_enable,
    output utld_calc_t                   res
);

    // Gregorian leap year over 1999..2128, given as year minus 2000.
    function automatic logic is_leap(input logic signed [8:0] yy);
        return (yy[1:0] == 2'b00) && (yy != 9'sd100);
    endfunction

    // Month length; a month outside 1..12 counts as 30 days.
    function automatic logic [4:0] days_of(input logic [MONTH_W-1:0] m, input logic leap);
        logic [4:0] len;
        case (m) inside
            MONTH_FEB:                         len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:           len = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8,
            4'd10, 4'd12:                      len = 5'd31;
            default:                           len = 5'd30;
        endcase
        return len;
    endfunction

    // Remainder by seven by folding octal digits, since 8 is 1 modulo 7.
    function automatic logic [2:0] mod7(input logic [7:0] x);
        logic [4:0] f1;
        logic [3:0] f2;
        f1 = {2'b00, x[2:0]} + {2'b00, x[5:3]} + {3'b000, x[7:6]};
        f2 = {1'b0, f1[2:0]} + {2'b00, f1[4:3]};
        return (f2 >= 4'd7) ? 3'(f2 - 4'd7) : f2[2:0];
    endfunction

    logic signed [OFFSET_W-1:0] off_c;
    logic signed [6:0]          hour_sum;
    logic signed [6:0]          hour_up;
    logic signed [6:0]          hour_dn;
    logic signed [8:0]          yy_in;
    logic signed [8:0]          yy_prev;
    logic [MONTH_W-1:0]         month_prev;
    logic [4:0]                 dim_in;
    logic [4:0]                 dim_prev;
    logic [5:0]                 day_inc;
    logic [HOUR_W-1:0]          hour_std;
    logic [5:0]                 day_adj;
    logic [MONTH_W-1:0]         month_adj;
    logic signed [8:0]          yy_adj;
    logic [7:0]                 wd_sum;
    logic [2:0]                 first_wd;
    logic [3:0]                 first_sun;
    logic [4:0]                 second_sun;
    logic                       in_window;

    // Clamp the offset and add it to the hour.
    assign off_c = (zone_offset < OFFSET_MIN) ? OFFSET_MIN :
                   (zone_offset > OFFSET_MAX) ? OFFSET_MAX : zone_offset;
    assign hour_sum = $signed({2'b00, item.hour}) + $signed({{2{off_c[OFFSET_W-1]}}, off_c});
    assign hour_up  = hour_sum + 7'sd24;
    assign hour_dn  = hour_sum - 7'sd24;

    // Neighbor dates for the carry in either direction.
    assign yy_in      = $signed({2'b00, item.year_low});
    assign month_prev = (item.month <= MONTH_JAN) ? MONTH_DEC : item.month - 4'd1;
    assign yy_prev    = (item.month <= MONTH_JAN) ? yy_in - 9'sd1 : yy_in;
    assign dim_in     = days_of(item.month, is_leap(yy_in));
    assign dim_prev   = days_of(month_prev, is_leap(yy_prev));
    assign day_inc    = {1'b0, item.day} + 6'd1;

    // Local standard date and hour.
    always_comb
    begin
        hour_std  = hour_sum[HOUR_W-1:0];
        day_adj   = {1'b0, item.day};
        month_adj = item.month;
        yy_adj    = yy_in;
        if (hour_sum < 7'sd0)
        begin
            hour_std = hour_up[HOUR_W-1:0];
            if (item.day <= 5'd1)
            begin
                day_adj   = {1'b0, dim_prev};
                month_adj = month_prev;
                yy_adj    = yy_prev;
            end
            else
            begin
                day_adj = {1'b0, item.day} - 6'd1;
            end
        end
        else if (hour_sum >= 7'sd24)
        begin
            hour_std = hour_dn[HOUR_W-1:0];
            if (day_inc > {1'b0, dim_in})
            begin
                day_adj = 6'd1;
                if (item.month >= MONTH_DEC)
                begin
                    month_adj = MONTH_JAN;
                    yy_adj    = yy_in + 9'sd1;
                end
                else
                begin
                    month_adj = item.month + 4'd1;
                end
            end
            else
            begin
                day_adj = day_inc;
            end
        end
    end

    // Weekday of the first of March or November; both share month key 2, and the
    // century terms of years 2000..2128 fold into the constant.
    assign wd_sum     = yy_adj[7:0] + {2'b00, yy_adj[7:2]} + 8'd3
                        - {7'd0, (yy_adj >= 9'sd100)};
    assign first_wd   = mod7(wd_sum);
    assign first_sun  = (first_wd == 3'd0) ? 4'd1 : 4'd8 - {1'b0, first_wd};
    assign second_sun = {1'b0, first_sun} + 5'd7;

    // US rule on local standard time.
    always_comb
    begin
        case (month_adj) inside
            MONTH_MAR:
                in_window = (day_adj > {1'b0, second_sun}) ||
                            ((day_adj == {1'b0, second_sun}) && (hour_std >= DST_SWITCH_HOUR));
            [MONTH_APR:MONTH_OCT]:
                in_window = 1'b1;
            MONTH_NOV:
                in_window = (day_adj < {2'b00, first_sun}) ||
                            ((day_adj == {2'b00, first_sun}) && (hour_std < DST_SWITCH_HOUR));
            default:
                in_window = 1'b0;
        endcase
    end

    // Add the daylight hour with wrap.
    always_comb
    begin
        res.dst_on = dst_enable && in_window;
        if (res.dst_on)
        begin
            res.local_hour = (hour_std == LAST_HOUR) ? '0 : hour_std + 5'd1;
        end
        else
        begin
            res.local_hour = hour_std;
        end
    end

endmodule

`default_nettype wire
